/* hw/rtl/sprcm_pkg.sv */
// Shared types, codes and helper functions of the sparse row/column map.
`timescale 1ns / 1ps
`default_nettype none
package sprcm_pkg;

    localparam int WORD_BITS = 32;
    localparam int SPAN_BITS = 17;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_REMOVE     = 3'd1;
    localparam logic [2:0] OP_LOOKUP     = 3'd2;
    localparam logic [2:0] OP_DEL_ROWS   = 3'd3;
    localparam logic [2:0] OP_DEL_COLS   = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_ROW    = 2'd2;

    localparam logic [1:0] MODE_EXACT    = 2'd0;
    localparam logic [1:0] MODE_LEFT     = 2'd1;
    localparam logic [1:0] MODE_RIGHT    = 2'd2;

    localparam logic [1:0] RD_ROW        = 2'd0;
    localparam logic [1:0] RD_LAST       = 2'd1;
    localparam logic [1:0] RD_FIRST      = 2'd2;
    localparam logic [1:0] RD_SEARCH     = 2'd3;

    localparam logic [1:0] SPAN_NONE     = 2'd0;
    localparam logic [1:0] SPAN_ROW      = 2'd1;
    localparam logic [1:0] SPAN_RANGE    = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [9:0]  row;
        logic [15:0] col;
        logic [15:0] range_from;
        logic [16:0] range_to;
        logic [1:0]  search;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_col;
        logic [9:0]  first_row;
        logic [10:0] end_row;
        logic        is_empty;
    } rsp_t;

    typedef struct packed {
        logic       capture;
        logic       set_stat;
        logic [1:0] stat;
        logic       insert;
        logic       clear;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       take_found;
        logic       search_start;
        logic       search_step;
        logic       sweep_start;
        logic [1:0] span_sel;
        logic       sweep_step;
        logic       scan_start;
        logic       col_check;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] mode;
        logic       row_ok;
        logic       empty;
        logic       in_bounds;
        logic       row_valid;
        logic       left_clamp;
        logic       right_clamp;
        logic       hit;
        logic       ptr_last;
        logic       w_last;
    } stat_t;

    function automatic logic [4:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [4:0] r;
        r = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (w[j])
                r = 5'(j);
        end
        return r;
    endfunction

    function automatic logic [4:0] highest_set(input logic [WORD_BITS-1:0] w);
        logic [4:0] r;
        r = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (w[j])
                r = 5'(j);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sprcm_stream_if.sv */
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none
interface sprcm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sprcm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sprcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/sprcm_ctrl.sv */
// Sequencer of the map: decodes each request and steps the datapath.
`timescale 1ns / 1ps
`default_nettype none
module sprcm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire sprcm_pkg::stat_t st,
    output sprcm_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SEARCH, S_RDDATA, S_CREAD, S_CCHK, S_SWEEP, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (!st.row_ok && (st.op == sprcm_pkg::OP_INSERT ||
                    st.op == sprcm_pkg::OP_REMOVE || st.op == sprcm_pkg::OP_LOOKUP))
                begin
                    cmd.set_stat = 1'b1;
                    cmd.stat     = sprcm_pkg::ST_BAD_ROW;
                end
                else
                begin
                    unique case (st.op)
                        sprcm_pkg::OP_INSERT: cmd.insert = 1'b1;
                        sprcm_pkg::OP_REMOVE:
                        begin
                            if (!st.empty && st.in_bounds)
                            begin
                                cmd.sweep_start = 1'b1;
                                cmd.span_sel    = sprcm_pkg::SPAN_ROW;
                                state_next      = S_SWEEP;
                            end
                        end
                        sprcm_pkg::OP_LOOKUP:
                        begin
                            if (st.empty)
                            begin
                                cmd.set_stat = 1'b1;
                                cmd.stat     = sprcm_pkg::ST_NOT_FOUND;
                            end
                            else if (st.left_clamp)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sprcm_pkg::RD_LAST;
                                state_next = S_RDDATA;
                            end
                            else if (st.right_clamp)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sprcm_pkg::RD_FIRST;
                                state_next = S_RDDATA;
                            end
                            else if (st.in_bounds && st.row_valid)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = sprcm_pkg::RD_ROW;
                                state_next = S_RDDATA;
                            end
                            else if (st.in_bounds && (st.mode == sprcm_pkg::MODE_LEFT ||
                                     st.mode == sprcm_pkg::MODE_RIGHT))
                            begin
                                cmd.search_start = 1'b1;
                                state_next       = S_SEARCH;
                            end
                            else
                            begin
                                cmd.set_stat = 1'b1;
                                cmd.stat     = sprcm_pkg::ST_NOT_FOUND;
                            end
                        end
                        sprcm_pkg::OP_DEL_ROWS:
                        begin
                            if (!st.empty)
                            begin
                                cmd.sweep_start = 1'b1;
                                cmd.span_sel    = sprcm_pkg::SPAN_RANGE;
                                state_next      = S_SWEEP;
                            end
                        end
                        sprcm_pkg::OP_DEL_COLS:
                        begin
                            if (!st.empty)
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_CREAD;
                            end
                        end
                        sprcm_pkg::OP_CLEAR: cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (st.hit)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sprcm_pkg::RD_SEARCH;
                    state_next = S_RDDATA;
                end
            end
            S_RDDATA:
            begin
                cmd.take_found = 1'b1;
                state_next     = S_FINISH;
            end
            S_CREAD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sprcm_pkg::RD_ROW;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                cmd.col_check = 1'b1;
                if (st.ptr_last)
                begin
                    cmd.sweep_start = 1'b1;
                    cmd.span_sel    = sprcm_pkg::SPAN_NONE;
                    state_next      = S_SWEEP;
                end
                else
                    state_next = S_CREAD;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (st.w_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DECODE)
        else $error("accepted beat did not reach decode");
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result was not presented");

endmodule
`default_nettype wire

/* hw/rtl/sprcm_dp.sv */
// Datapath of the map: valid bits, bounds, column store, scans and result.
`timescale 1ns / 1ps
`default_nettype none
module sprcm_dp #(
    parameter int ROWS     = 1024,
    parameter int COL_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sprcm_pkg::req_t  req_data,
    input  wire sprcm_pkg::cmd_t  cmd,
    output sprcm_pkg::stat_t      st,
    output sprcm_pkg::rsp_t       rsp_data
);

    localparam int W   = sprcm_pkg::WORD_BITS;
    localparam int NW  = (ROWS + W - 1) / W;
    localparam int PW  = NW * W;
    localparam int PIW = $clog2(PW);
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
    localparam int RIW = $clog2(ROWS);
    localparam int BW  = $clog2(ROWS + 1);
    localparam int SW  = sprcm_pkg::SPAN_BITS;

    logic [2:0]          op_reg;
    logic [1:0]          mode_reg;
    logic [RIW-1:0]      pos_reg;
    logic                row_ok_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [15:0]         from_reg;
    logic [SW-1:0]       to_reg;

    logic [PW-1:0]       valid_reg, valid_next;
    logic [RIW-1:0]      low_reg, low_next;
    logic [BW-1:0]       high_reg, high_next;
    logic                empty_reg, empty_next;

    logic [SW-1:0]       span_lo_reg, span_hi_reg;
    logic [WIW-1:0]      w_reg;
    logic [RIW-1:0]      ptr_reg;
    logic                acc_any_reg;
    logic [RIW-1:0]      acc_lo_reg;
    logic [BW-1:0]       acc_hi_reg;

    logic [1:0]          stat_reg;
    logic [COL_BITS-1:0] found_reg;
    sprcm_pkg::rsp_t     out_reg;

    logic [COL_BITS-1:0] rdata;
    logic [RIW-1:0]      raddr;

    logic [WIW-1:0]      pos_w;
    logic [4:0]          pos_b;
    logic [PIW-1:0]      base;
    logic [W-1:0]        word_cur, search_word, span_mask, word_new;
    logic [4:0]          bit_lo, bit_hi, srch_bit;
    logic [PIW-1:0]      idx_lo, idx_hi, idx_srch;
    logic                acc_any_n;
    logic [RIW-1:0]      acc_lo_n;
    logic [BW-1:0]       acc_hi_n;
    logic                col_in_span;

    assign pos_w    = WIW'(PIW'(pos_reg) >> 5);
    assign pos_b    = 5'(pos_reg);
    assign base     = PIW'(w_reg) << 5;
    assign word_cur = valid_reg[base +: W];

    // The starting word of a search hides the row itself and the rows on the far side.
    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            if (mode_reg == sprcm_pkg::MODE_LEFT)
                search_word[j] = word_cur[j] && ((w_reg != pos_w) || (5'(j) < pos_b));
            else
                search_word[j] = word_cur[j] && ((w_reg != pos_w) || (5'(j) > pos_b));
            span_mask[j] = ((SW'(base) + SW'(j)) >= span_lo_reg) &&
                           ((SW'(base) + SW'(j)) < span_hi_reg);
        end
    end

    assign word_new = word_cur & ~span_mask;
    assign bit_lo   = sprcm_pkg::lowest_set(word_new);
    assign bit_hi   = sprcm_pkg::highest_set(word_new);
    assign srch_bit = (mode_reg == sprcm_pkg::MODE_LEFT) ? sprcm_pkg::highest_set(search_word)
                                                         : sprcm_pkg::lowest_set(search_word);
    assign idx_lo   = base | PIW'(bit_lo);
    assign idx_hi   = base | PIW'(bit_hi);
    assign idx_srch = base | PIW'(srch_bit);

    assign acc_any_n = acc_any_reg || (word_new != '0);
    assign acc_lo_n  = (!acc_any_reg && word_new != '0) ? RIW'(idx_lo) : acc_lo_reg;
    assign acc_hi_n  = (word_new != '0) ? (BW'(idx_hi) + BW'(1)) : acc_hi_reg;

    assign col_in_span = (SW'(rdata) >= SW'(from_reg)) && (SW'(rdata) < to_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            sprcm_pkg::RD_LAST:   raddr = RIW'(high_reg - BW'(1));
            sprcm_pkg::RD_FIRST:  raddr = low_reg;
            sprcm_pkg::RD_SEARCH: raddr = RIW'(idx_srch);
            default:              raddr = (op_reg == sprcm_pkg::OP_DEL_COLS) ? ptr_reg : pos_reg;
        endcase
    end

    sprcm_ram #(.WIDTH(COL_BITS), .DEPTH(ROWS)) u_col_ram (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (pos_reg),
        .wdata (col_reg),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        empty_next = empty_reg;
        if (cmd.insert)
        begin
            valid_next[PIW'(pos_reg)] = 1'b1;
            if (empty_reg || pos_reg < low_reg)
                low_next = pos_reg;
            if (empty_reg || BW'(pos_reg) >= high_reg)
                high_next = BW'(pos_reg) + BW'(1);
            empty_next = 1'b0;
        end
        if (cmd.clear)
        begin
            valid_next = '0;
            low_next   = '0;
            high_next  = '0;
            empty_next = 1'b1;
        end
        if (cmd.col_check && col_in_span)
            valid_next[PIW'(ptr_reg)] = 1'b0;
        if (cmd.sweep_step)
        begin
            valid_next[base +: W] = word_new;
            if (st.w_last)
            begin
                low_next   = acc_any_n ? acc_lo_n : '0;
                high_next  = acc_any_n ? acc_hi_n : '0;
                empty_next = !acc_any_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= req_data.op;
            mode_reg   <= req_data.search;
            pos_reg    <= RIW'(req_data.row);
            row_ok_reg <= SW'(req_data.row) < SW'(ROWS);
            col_reg    <= COL_BITS'(req_data.col);
            from_reg   <= req_data.range_from;
            to_reg     <= req_data.range_to;
            stat_reg   <= sprcm_pkg::ST_OK;
            found_reg  <= '0;
        end
        if (cmd.set_stat)
            stat_reg <= cmd.stat;
        if (cmd.take_found)
            found_reg <= rdata;
        if (cmd.search_start)
            w_reg <= pos_w;
        if (cmd.search_step && !st.hit)
        begin
            if (mode_reg == sprcm_pkg::MODE_LEFT)
                w_reg <= w_reg - WIW'(1);
            else
                w_reg <= w_reg + WIW'(1);
        end
        if (cmd.sweep_start)
        begin
            w_reg       <= '0;
            acc_any_reg <= 1'b0;
            case (cmd.span_sel)
                sprcm_pkg::SPAN_ROW:
                begin
                    span_lo_reg <= SW'(pos_reg);
                    span_hi_reg <= SW'(pos_reg) + SW'(1);
                end
                sprcm_pkg::SPAN_RANGE:
                begin
                    span_lo_reg <= SW'(from_reg);
                    span_hi_reg <= to_reg;
                end
                default:
                begin
                    span_lo_reg <= '0;
                    span_hi_reg <= '0;
                end
            endcase
        end
        if (cmd.sweep_step)
        begin
            w_reg       <= w_reg + WIW'(1);
            acc_any_reg <= acc_any_n;
            acc_lo_reg  <= acc_lo_n;
            acc_hi_reg  <= acc_hi_n;
        end
        if (cmd.scan_start)
            ptr_reg <= low_reg;
        if (cmd.col_check)
            ptr_reg <= ptr_reg + RIW'(1);
        if (cmd.load_out)
        begin
            out_reg.status    <= stat_reg;
            out_reg.found_col <= 16'(found_reg);
            out_reg.first_row <= 10'(low_reg);
            out_reg.end_row   <= 11'(high_reg);
            out_reg.is_empty  <= empty_reg;
        end
    end

    assign rsp_data       = out_reg;
    assign st.op          = op_reg;
    assign st.mode        = mode_reg;
    assign st.row_ok      = row_ok_reg;
    assign st.empty       = empty_reg;
    assign st.in_bounds   = (pos_reg >= low_reg) && (BW'(pos_reg) < high_reg);
    assign st.row_valid   = valid_reg[PIW'(pos_reg)];
    assign st.left_clamp  = (mode_reg == sprcm_pkg::MODE_LEFT) && (BW'(pos_reg) >= high_reg);
    assign st.right_clamp = (mode_reg == sprcm_pkg::MODE_RIGHT) && (pos_reg < low_reg);
    assign st.hit         = (search_word != '0);
    assign st.ptr_last    = (BW'(ptr_reg) + BW'(1)) == high_reg;
    assign st.w_last      = (w_reg == WIW'(NW - 1));

    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (low_reg == '0 && high_reg == '0))
        else $error("empty table with nonzero bounds");
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (high_reg > BW'(low_reg)))
        else $error("occupied table with inverted bounds");

endmodule
`default_nettype wire

/* hw/rtl/sparse_row_column_map.sv */
// Top level of the sparse row/column map: sequencer and datapath.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    op, row, col, range_from, range_to, search
//  rsp      out  valid/ready    status, found_col, first_row, end_row, is_empty
//
// One request at a time; each beat gives exactly one response beat.
// Insert, clear and bad rows go through decode and finish; a direct lookup also reads the column RAM.
// Neighbor lookups scan the valid bits one 32-row word at a time.
// Row removes and row-span deletes sweep all (ROWS+31)/32 words of valid bits;
// a column-span delete reads the column RAM for each row in bounds, then sweeps.
// Reset clears all valid bits at once; a held response does not block acceptance.
`timescale 1ns / 1ps
`default_nettype none
module sparse_row_column_map #(
    parameter int ROWS     = 1024,
    parameter int COL_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    sprcm_stream_if.sink   req,
    sprcm_stream_if.source rsp
);

    sprcm_pkg::cmd_t  cmd;
    sprcm_pkg::stat_t st;

    sprcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    sprcm_dp #(.ROWS(ROWS), .COL_BITS(COL_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .st       (st),
        .rsp_data (rsp.data)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_sparse_row_column_map.sv */
// Self-checking testbench of the sparse row/column map with its own table predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_sparse_row_column_map;

    localparam int NROWS = 1024;
    localparam int WATCH_LIMIT = 20000;

    // Op codes and a search mode that the block leaves without effect.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sprcm_stream_if #(.T(sprcm_pkg::req_t)) req ();
    sprcm_stream_if #(.T(sprcm_pkg::rsp_t)) rsp ();

    sparse_row_column_map #(.ROWS(NROWS), .COL_BITS(16)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    always #6 clk = ~clk;

    // Predictor copy of the table.
    bit          occ [NROWS];
    logic [15:0] colv [NROWS];
    int          lo_b;
    int          hi_b;
    bit          empt;

    sprcm_pkg::rsp_t expected_rsps [$];
    int   errors;
    int   idle_cycles;
    int   rsp_wait;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void rebound();
        lo_b = 0;
        hi_b = 0;
        empt = 1'b1;
        for (int i = 0; i < NROWS; i++)
        begin
            if (occ[i])
            begin
                if (empt)
                    lo_b = i;
                empt = 1'b0;
                hi_b = i + 1;
            end
        end
    endfunction

    function automatic bit find_col(input int pos, input logic [1:0] mode,
                                    output logic [15:0] c);
        c = '0;
        if (empt)
            return 0;
        if (mode == sprcm_pkg::MODE_LEFT && pos >= hi_b)
        begin
            c = colv[hi_b - 1];
            return 1;
        end
        if (mode == sprcm_pkg::MODE_RIGHT && pos < lo_b)
        begin
            c = colv[lo_b];
            return 1;
        end
        if (pos < lo_b || pos >= hi_b)
            return 0;
        if (occ[pos])
        begin
            c = colv[pos];
            return 1;
        end
        if (mode == sprcm_pkg::MODE_LEFT)
        begin
            for (int p = pos - 1; p >= lo_b; p--)
                if (occ[p])
                begin
                    c = colv[p];
                    return 1;
                end
        end
        if (mode == sprcm_pkg::MODE_RIGHT)
        begin
            for (int p = pos + 1; p < hi_b; p++)
                if (occ[p])
                begin
                    c = colv[p];
                    return 1;
                end
        end
        return 0;
    endfunction

    function automatic sprcm_pkg::rsp_t predict_table_op(input sprcm_pkg::req_t r);
        sprcm_pkg::rsp_t o;
        int   a;
        int   b;
        logic [15:0] c;
        o = '0;
        case (r.op)
            sprcm_pkg::OP_INSERT:
            begin
                if (empt || r.row < lo_b)
                    lo_b = r.row;
                if (empt || r.row >= hi_b)
                    hi_b = r.row + 1;
                empt = 1'b0;
                occ[r.row] = 1'b1;
                colv[r.row] = r.col;
            end
            sprcm_pkg::OP_REMOVE:
            begin
                if (!empt && r.row >= lo_b && r.row < hi_b)
                begin
                    occ[r.row] = 1'b0;
                    rebound();
                end
            end
            sprcm_pkg::OP_LOOKUP:
            begin
                if (find_col(r.row, r.search, c))
                    o.found_col = c;
                else
                    o.status = sprcm_pkg::ST_NOT_FOUND;
            end
            sprcm_pkg::OP_DEL_ROWS:
            begin
                if (!empt)
                begin
                    a = (r.range_from < lo_b) ? lo_b : r.range_from;
                    b = (r.range_to > hi_b) ? hi_b : r.range_to;
                    for (int p = a; p < b; p++)
                        occ[p] = 1'b0;
                    rebound();
                end
            end
            sprcm_pkg::OP_DEL_COLS:
            begin
                if (!empt)
                begin
                    for (int p = lo_b; p < hi_b; p++)
                        if (occ[p] && colv[p] >= r.range_from && colv[p] < r.range_to)
                            occ[p] = 1'b0;
                    rebound();
                end
            end
            sprcm_pkg::OP_CLEAR:
            begin
                foreach (occ[i])
                    occ[i] = 1'b0;
                rebound();
            end
            default:
            begin
            end
        endcase
        o.first_row = 10'(lo_b);
        o.end_row = 11'(hi_b);
        o.is_empty = empt;
        return o;
    endfunction

    // Valid stays high after an accepted beat until the next item or the end of the run.
    task automatic send_item(input sprcm_pkg::req_t r);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_rsps.push_back(predict_table_op(r));
    endtask

    function automatic sprcm_pkg::req_t make_req(input logic [2:0] op, input int row,
                                                 input logic [1:0] mode);
        sprcm_pkg::req_t r;
        r.op = op;
        r.row = 10'(row);
        r.col = 16'($urandom);
        r.range_from = 16'($urandom);
        r.range_to = 17'($urandom);
        r.search = mode;
        return r;
    endfunction

    // Response side: after each beat, ready may stay low for a randomly drawn wait counted down in rsp_wait.
    always @(posedge clk)
    begin
        sprcm_pkg::rsp_t want;
        int w;
        w = $urandom_range(0, 3);
        if (rsp.valid && rsp.ready)
        begin
            if (expected_rsps.size() == 0)
                report("unexpected beat", 1, 0);
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.data.status !== want.status)
                    report("status", rsp.data.status, want.status);
                if (rsp.data.found_col !== want.found_col)
                    report("found_col", rsp.data.found_col, want.found_col);
                if (rsp.data.first_row !== want.first_row)
                    report("first_row", rsp.data.first_row, want.first_row);
                if (rsp.data.end_row !== want.end_row)
                    report("end_row", rsp.data.end_row, want.end_row);
                if (rsp.data.is_empty !== want.is_empty)
                    report("is_empty", rsp.data.is_empty, want.is_empty);
            end
        end
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_wait <= w;
                rsp.ready <= (w == 0);
            end
            else if (rsp_wait != 0)
            begin
                rsp_wait <= rsp_wait - 1;
                rsp.ready <= (rsp_wait == 1);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        sprcm_pkg::req_t r;
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 5, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_DEL_ROWS, 0, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_DEL_COLS, 0, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_REMOVE, 3, sprcm_pkg::MODE_EXACT));
        r = make_req(sprcm_pkg::OP_INSERT, 0, sprcm_pkg::MODE_EXACT);
        r.col = 16'h0000;
        send_item(r);
        r = make_req(sprcm_pkg::OP_INSERT, NROWS - 1, sprcm_pkg::MODE_EXACT);
        r.col = 16'hffff;
        send_item(r);
        send_item(make_req(sprcm_pkg::OP_INSERT, 500, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 400, sprcm_pkg::MODE_LEFT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 400, sprcm_pkg::MODE_RIGHT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 400, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 500, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 3, MODE_SPARE));
        send_item(make_req(sprcm_pkg::OP_REMOVE, 0, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 0, sprcm_pkg::MODE_RIGHT));
        send_item(make_req(sprcm_pkg::OP_REMOVE, NROWS - 1, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, NROWS - 1, sprcm_pkg::MODE_LEFT));
        send_item(make_req(sprcm_pkg::OP_LOOKUP, 0, sprcm_pkg::MODE_LEFT));
        send_item(make_req(sprcm_pkg::OP_REMOVE, 10, sprcm_pkg::MODE_EXACT));
        r = make_req(sprcm_pkg::OP_DEL_ROWS, 0, sprcm_pkg::MODE_EXACT);
        r.range_from = 16'hffff;
        r.range_to = 17'd0;
        send_item(r);
        r = make_req(sprcm_pkg::OP_DEL_COLS, 0, sprcm_pkg::MODE_EXACT);
        r.range_from = 16'd0;
        r.range_to = 17'h10000;
        send_item(r);
        send_item(make_req(OP_SPARE_LO, 7, sprcm_pkg::MODE_EXACT));
        send_item(make_req(OP_SPARE_HI, 7, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_INSERT, 77, sprcm_pkg::MODE_EXACT));
        send_item(make_req(sprcm_pkg::OP_CLEAR, 0, sprcm_pkg::MODE_EXACT));
    endtask

    // Mostly inserts and lookups near a small cluster, plus deletes and noise.
    task automatic test_random(input int count);
        sprcm_pkg::req_t r;
        int   k;
        int   base;
        base = $urandom_range(0, NROWS - 64);
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if ((n % 200) == 199)
                base = $urandom_range(0, NROWS - 64);
            r = make_req(sprcm_pkg::OP_INSERT, base + $urandom_range(0, 63),
                         2'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0)
                r.row = 10'($urandom);
            if (k < 35)
                r.op = sprcm_pkg::OP_INSERT;
            else if (k < 45)
                r.op = sprcm_pkg::OP_REMOVE;
            else if (k < 80)
                r.op = sprcm_pkg::OP_LOOKUP;
            else if (k < 86)
            begin
                r.op = sprcm_pkg::OP_DEL_ROWS;
                r.range_from = 16'(base + $urandom_range(0, 63));
                r.range_to = 17'(r.range_from + $urandom_range(0, 16));
                if ($urandom_range(0, 3) == 0)
                    r.range_from = 16'($urandom);
            end
            else if (k < 93)
            begin
                r.op = sprcm_pkg::OP_DEL_COLS;
                r.range_to = 17'(r.range_from + $urandom_range(0, 4000));
                if ($urandom_range(0, 3) == 0)
                    r.range_to = 17'($urandom);
            end
            else if (k < 96)
                r.op = sprcm_pkg::OP_CLEAR;
            else
                r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
            send_item(r);
        end
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        rsp_wait = 0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        foreach (occ[i])
        begin
            occ[i] = 1'b0;
            colv[i] = '0;
        end
        rebound();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1130);
        req.valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

/* sparse_row_column_map.f */
hw/rtl/sprcm_pkg.sv
hw/rtl/sprcm_stream_if.sv
hw/rtl/sprcm_ram.sv
hw/rtl/sprcm_ctrl.sv
hw/rtl/sprcm_dp.sv
hw/rtl/sparse_row_column_map.sv
tb/sv/tb_sparse_row_column_map.sv
